// ===== design/assert_macros.svh =====
// Assertion macros for the checker file of the clock block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME_CYCLE(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT_CYCLE(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle assertion failed");

`endif

// ===== design/crtc_pkg.sv =====
// Package: command codes, register numbers, widths and helpers for the clock block.
`timescale 1ns / 1ps

package crtc_pkg;

  localparam int CmdWidth  = 2;
  localparam int RegWidth  = 4;
  localparam int DataWidth = 8;
  localparam int SecWidth  = 6;
  localparam int MinWidth  = 6;
  localparam int HourWidth = 5;
  localparam int DayWidth  = 9;

  // Command codes
  localparam logic [CmdWidth-1:0] CMD_TICK  = 2'd0;
  localparam logic [CmdWidth-1:0] CMD_READ  = 2'd1;
  localparam logic [CmdWidth-1:0] CMD_WRITE = 2'd2;

  // Clock register numbers
  localparam logic [RegWidth-1:0] REG_SEC  = 4'd8;
  localparam logic [RegWidth-1:0] REG_MIN  = 4'd9;
  localparam logic [RegWidth-1:0] REG_HOUR = 4'd10;
  localparam logic [RegWidth-1:0] REG_DAYL = 4'd11;
  localparam logic [RegWidth-1:0] REG_DAYH = 4'd12;

  // One item as handed to the time-keeping unit
  typedef struct packed {
    logic                 valid;
    logic [CmdWidth-1:0]  cmd;
    logic [RegWidth-1:0]  reg_number;
    logic [DataWidth-1:0] write_data;
  } op_t;

  // Byte modulo 60: remove 240, 120 and 60 in turn
  function automatic logic [SecWidth-1:0] mod60(input logic [DataWidth-1:0] d);
    logic [DataWidth-1:0] r;
    r = d;
    if (r >= 8'd240) r = r - 8'd240;
    if (r >= 8'd120) r = r - 8'd120;
    if (r >= 8'd60)  r = r - 8'd60;
    return r[SecWidth-1:0];
  endfunction

  // Byte modulo 24: remove 192, 96, 48 and 24 in turn
  function automatic logic [HourWidth-1:0] mod24(input logic [DataWidth-1:0] d);
    logic [DataWidth-1:0] r;
    r = d;
    if (r >= 8'd192) r = r - 8'd192;
    if (r >= 8'd96)  r = r - 8'd96;
    if (r >= 8'd48)  r = r - 8'd48;
    if (r >= 8'd24)  r = r - 8'd24;
    return r[HourWidth-1:0];
  endfunction

endpackage

// ===== design/crtc_clock.sv =====
// Time-keeping unit: second, minute, hour and day counters with register access.
`timescale 1ns / 1ps

module crtc_clock (
  input  logic                          clk,
  input  logic                          rst,
  input  crtc_pkg::op_t                 op,
  output logic [crtc_pkg::DataWidth-1:0] rd_value
);

  logic [crtc_pkg::SecWidth-1:0]  seconds_count, seconds_count_next;
  logic [crtc_pkg::MinWidth-1:0]  minutes_count, minutes_count_next;
  logic [crtc_pkg::HourWidth-1:0] hours_count, hours_count_next;
  logic [crtc_pkg::DayWidth-1:0]  days_count, days_count_next;

  logic sec_wrap, min_wrap, hour_wrap;

  // Carry chain for a one-second tick
  assign sec_wrap  = (seconds_count >= 6'd59);
  assign min_wrap  = (minutes_count >= 6'd59);
  assign hour_wrap = (hours_count >= 5'd23);

  // Work out the next counter values for the item in hand
  always_comb begin
    seconds_count_next = seconds_count;
    minutes_count_next = minutes_count;
    hours_count_next   = hours_count;
    days_count_next    = days_count;
    if (op.valid) begin
      case (op.cmd)
        crtc_pkg::CMD_TICK: begin
          seconds_count_next = sec_wrap ? '0 : seconds_count + 6'd1;
          if (sec_wrap) begin
            minutes_count_next = min_wrap ? '0 : minutes_count + 6'd1;
            if (min_wrap) begin
              hours_count_next = hour_wrap ? '0 : hours_count + 5'd1;
              // Day count wraps at 512 by its width
              if (hour_wrap) days_count_next = days_count + 9'd1;
            end
          end
        end
        crtc_pkg::CMD_WRITE: begin
          case (op.reg_number)
            crtc_pkg::REG_SEC:  seconds_count_next = crtc_pkg::mod60(op.write_data);
            crtc_pkg::REG_MIN:  minutes_count_next = crtc_pkg::mod60(op.write_data);
            crtc_pkg::REG_HOUR: hours_count_next   = crtc_pkg::mod24(op.write_data);
            crtc_pkg::REG_DAYL: days_count_next    = {days_count[8], op.write_data};
            crtc_pkg::REG_DAYH: days_count_next    = {op.write_data[0], days_count[7:0]};
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  // Hold the counters, cleared on reset
  always_ff @(posedge clk) begin
    if (rst) begin
      seconds_count <= '0;
      minutes_count <= '0;
      hours_count   <= '0;
      days_count    <= '0;
    end else begin
      seconds_count <= seconds_count_next;
      minutes_count <= minutes_count_next;
      hours_count   <= hours_count_next;
      days_count    <= days_count_next;
    end
  end

  // Select the register for a read, unknown numbers read as zero
  always_comb begin
    case (op.reg_number)
      crtc_pkg::REG_SEC:  rd_value = {2'b00, seconds_count};
      crtc_pkg::REG_MIN:  rd_value = {2'b00, minutes_count};
      crtc_pkg::REG_HOUR: rd_value = {3'b000, hours_count};
      crtc_pkg::REG_DAYL: rd_value = days_count[7:0];
      crtc_pkg::REG_DAYH: rd_value = {7'd0, days_count[8]};
      default:            rd_value = '0;
    endcase
  end

endmodule

// ===== design/cartridge_rtc_registers_top.sv =====
// Cartridge real-time clock: input register, counter update, read result register.
// Path: a read item passes the input register and then the result register to
// read_data.
// Throughput: one item per cycle; a read waits in the input register only while
// a previous result is held by out_stall.
// Reset: rst clears both valid flags and all four counters to zero.
`timescale 1ns / 1ps

module cartridge_rtc_registers_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [crtc_pkg::CmdWidth-1:0]  cmd,
  input  logic [crtc_pkg::RegWidth-1:0]  reg_number,
  input  logic [crtc_pkg::DataWidth-1:0] write_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [crtc_pkg::DataWidth-1:0] read_data
);

  logic                           in_q_valid;
  logic [crtc_pkg::CmdWidth-1:0]  cmd_q;
  logic [crtc_pkg::RegWidth-1:0]  reg_number_q;
  logic [crtc_pkg::DataWidth-1:0] write_data_q;
  logic                           advance;
  logic                           is_read;
  crtc_pkg::op_t                  op;
  logic [crtc_pkg::DataWidth-1:0] rd_value;

  // Only a read needs room in the result register
  assign is_read  = (cmd_q == crtc_pkg::CMD_READ);
  assign advance  = in_q_valid && (!is_read || !out_valid || !out_stall);
  assign in_stall = in_q_valid && !advance;

  // Input register: take a new transfer whenever it is empty or the held item moves on
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (!in_stall) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      cmd_q        <= cmd;
      reg_number_q <= reg_number;
      write_data_q <= write_data;
    end
  end

  assign op = '{valid: advance, cmd: cmd_q, reg_number: reg_number_q,
                write_data: write_data_q};

  crtc_clock u_clock (
    .clk      (clk),
    .rst      (rst),
    .op       (op),
    .rd_value (rd_value)
  );

  // Result register: load on a read, drop once transferred
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && is_read) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && is_read) begin
      read_data <= rd_value;
    end
  end

endmodule

// ===== design/crtc_checker.sv =====
// Port checker for the clock block, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module crtc_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [crtc_pkg::DataWidth-1:0] read_data
);

  // A held result stays until transferred
  `ASSERT_NEXT_CYCLE(a_out_hold, clk, rst, out_valid && out_stall, out_valid)
  `ASSERT_NEXT_CYCLE(a_out_stable, clk, rst, out_valid && out_stall, $stable(read_data))
  // The input side backs up only behind a held result
  `ASSERT_SAME_CYCLE(a_stall_cause, clk, rst, in_stall, out_valid && out_stall)
  // Reset leaves no result pending and the input open
  `ASSERT_NEXT_CYCLE(a_reset_clear, clk, 1'b0, rst, !out_valid && !in_stall)

endmodule

bind cartridge_rtc_registers_top crtc_checker u_crtc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .read_data (read_data)
);
